// ----- hw/rtl/hcl2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hcl2rgb_pkg: shared types and constants for the HCL to RGB converter
// Reciprocal constants for the constant dividers, luma weights, sector codes
// and the per-channel result type.
// ----------------------------------------------------------------------------
`default_nettype none

package hcl2rgb_pkg;

    localparam int HUE_W   = 15;
    localparam int LEVEL_W = 17;
    localparam int Q_W     = 10;  // hue / sector width, at most 8 for any hue
    localparam int Q6_W    = 8;   // sector count / 6

    // floor(x / 60) = (x * 34953) >> 21, exact for x < 2^15
    localparam logic [15:0] DIV60_MUL   = 16'd34953;
    localparam int          DIV60_SHIFT = 21;
    // floor(q / 6) = (q * 1366) >> 13, exact for q < 1024
    localparam logic [10:0] DIV6_MUL    = 11'd1366;
    localparam int          DIV6_SHIFT  = 13;
    // floor(z / 25) = (z * 5243) >> 17, exact for z < 6400
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;

    // Luma weights in percent
    localparam int WEIGHT_R   = 30;
    localparam int WEIGHT_G   = 59;
    localparam int WEIGHT_B   = 11;
    localparam int WEIGHT_SUM = 100;

    // 255 / 6000 reduces to 17 / 400; half of 400 gives the rounding offset
    localparam int CHAN_MUL   = 17;
    localparam int ROUND_HALF = 200;
    // 256 * 400: at or above this the rounded channel exceeds 255
    localparam logic [16:0] SAT_LIMIT = 17'd102400;

    typedef enum logic [2:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic [7:0] value;
        logic       clip;
    } chan_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hcl2rgb_chan.sv -----
// ----------------------------------------------------------------------------
// hcl2rgb_chan: channel scale, round and saturate
// Forms one channel numerator, scales it by 255 over the common denominator,
// rounds half away from zero and saturates to 0..255 over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hcl2rgb_chan
    import hcl2rgb_pkg::*;
#(
    parameter int PW = 29,
    parameter int NW = 38,
    parameter int K  = 22
) (
    input  wire logic            aclk,
    input  wire logic            advance,
    input  wire logic [PW-1:0]   ch,
    input  wire logic [NW-1:0]   base,
    output chan_res_t            res
);

    localparam int AW = NW + 5;

    logic [NW-1:0] mag_reg, mag_next;
    logic          neg_a_reg, neg_a_next;
    logic [12:0]   z_reg, z_next;
    logic          big_reg, big_next;
    logic          neg_b_reg, neg_b_next;
    chan_res_t     res_reg, res_next;

    logic [NW-1:0] num;
    logic [AW-1:0] acc;
    logic [AW-1:0] y;
    logic [25:0]   p25;
    logic [7:0]    t;

    // numerator = 100 * channel + offset, kept as sign and magnitude
    always_comb begin
        num        = NW'(ch) * NW'(WEIGHT_SUM) + base;
        neg_a_next = num[NW-1];
        mag_next   = num[NW-1] ? (~num + NW'(1)) : num;
    end

    // drop the low K bits after adding half the divisor
    always_comb begin
        acc        = AW'(mag_reg) * AW'(CHAN_MUL) + (AW'(ROUND_HALF) << K);
        y          = acc >> K;
        big_next   = (y >= AW'(SAT_LIMIT));
        z_next     = y[16:4];
        neg_b_next = neg_a_reg;
    end

    always_comb begin
        p25 = 26'(z_reg) * 26'(DIV25_MUL);
        t   = p25[DIV25_SHIFT +: 8];
        if (neg_b_reg) begin
            res_next.value = 8'd0;
            res_next.clip  = big_reg || (t != 8'd0);
        end else if (big_reg) begin
            res_next.value = 8'hFF;
            res_next.clip  = 1'b1;
        end else begin
            res_next.value = t;
            res_next.clip  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mag_reg   <= mag_next;
            neg_a_reg <= neg_a_next;
            z_reg     <= z_next;
            big_reg   <= big_next;
            neg_b_reg <= neg_b_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/hcl_to_rgb_convert.sv -----
// Throughput: one request per cycle; a stall on m_tready holds every stage.
// The whole datapath is a single stall-together pipeline whose depth is set
// by the sector divide, the chroma multiply and the round/saturate stages.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// hcl_to_rgb_convert: HCL to RGB colour conversion, Rec.601 luma weights
// Splits the hue into a sector and position, builds chroma and the second
// component, adds the luma offset and rounds each channel to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hcl_to_rgb_convert
    import hcl2rgb_pkg::*;
#(
    parameter int LEVEL_QBITS = 16,
    parameter int HUE_QBITS   = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // hue_angle[14:0], chroma_level[31:15],
                                       // luma_level[48:32], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // red_out[7:0], green_out[15:8],
                                       // blue_out[23:16]
    output logic             m_tuser   // clipped
);

    localparam int WB    = HUE_QBITS + 6;    // sector width in hue units
    localparam int PW    = WB + LEVEL_W;     // chroma times hue units
    localparam int NW    = PW + 9;           // signed channel numerator
    localparam int K     = HUE_QBITS + LEVEL_QBITS;
    localparam int DEPTH = 7;
    localparam logic [WB-1:0] WSEC = WB'(60 << HUE_QBITS);

    logic advance;
    logic [DEPTH-1:0] valid_reg, valid_next;

    // stage 1
    logic [HUE_W-1:0]   hue1_reg, hue1_next;
    logic [LEVEL_W-1:0] c1_reg, c1_next, l1_reg, l1_next;
    logic [Q_W-1:0]     qd1_reg, qd1_next;
    // stage 2
    sector_t            sect2_reg, sect2_next;
    logic [WB-1:0]      pos2_reg, pos2_next;
    logic [LEVEL_W-1:0] c2_reg, c2_next, l2_reg, l2_next;
    // stage 3
    sector_t            sect3_reg, sect3_next;
    logic [PW-1:0]      cc3_reg, cc3_next, xx3_reg, xx3_next, lw3_reg, lw3_next;
    // stage 4
    logic [PW-1:0]      r4_reg, r4_next, g4_reg, g4_next, b4_reg, b4_next;
    logic [NW-1:0]      base4_reg, base4_next;

    logic [HUE_W-1:0] xh;
    logic [30:0]      p60;
    logic [20:0]      p6;
    logic [Q6_W-1:0]  q6;
    logic [Q_W-1:0]   rem6;
    logic [31:0]      qw;
    logic [HUE_W-1:0] posf;
    logic [WB-1:0]    qq;
    logic [NW-1:0]    wsum;

    chan_res_t res_r, res_g, res_b;

    // the whole pipe moves unless a finished result is held at the output
    assign advance    = !valid_reg[DEPTH-1] || m_tready;
    assign s_tready   = advance;
    assign valid_next = {valid_reg[DEPTH-2:0], s_tvalid};

    // stage 1: hue / (60 << HUE_QBITS) by reciprocal
    always_comb begin
        hue1_next = s_tdata[14:0];
        c1_next   = s_tdata[31:15];
        l1_next   = s_tdata[48:32];
        xh        = s_tdata[14:0] >> HUE_QBITS;
        p60       = 31'(xh) * 31'(DIV60_MUL);
        qd1_next  = p60[DIV60_SHIFT +: Q_W];
    end

    // stage 2: sector = quotient mod 6, position within the sector
    always_comb begin
        p6         = 21'(qd1_reg) * 21'(DIV6_MUL);
        q6         = p6[DIV6_SHIFT +: Q6_W];
        rem6       = qd1_reg - Q_W'(11'(q6) * 11'd6);
        sect2_next = sector_t'(rem6[2:0]);
        qw         = (32'(qd1_reg) * 32'd60) << HUE_QBITS;
        posf       = hue1_reg - qw[HUE_W-1:0];
        pos2_next  = WB'(posf);
        c2_next    = c1_reg;
        l2_next    = l1_reg;
    end

    // stage 3: triangle position and the three products
    always_comb begin
        qq         = sect2_reg[0] ? (WSEC - pos2_reg) : pos2_reg;
        cc3_next   = PW'(c2_reg) * PW'(WSEC);
        xx3_next   = PW'(c2_reg) * PW'(qq);
        lw3_next   = PW'(l2_reg) * PW'(WSEC);
        sect3_next = sect2_reg;
    end

    // stage 4: order chroma, second component and zero; luma offset
    always_comb begin
        unique case (sect3_reg)
            SECT_RED_YEL: begin
                r4_next = cc3_reg; g4_next = xx3_reg; b4_next = '0;
            end
            SECT_YEL_GRN: begin
                r4_next = xx3_reg; g4_next = cc3_reg; b4_next = '0;
            end
            SECT_GRN_CYN: begin
                r4_next = '0; g4_next = cc3_reg; b4_next = xx3_reg;
            end
            SECT_CYN_BLU: begin
                r4_next = '0; g4_next = xx3_reg; b4_next = cc3_reg;
            end
            SECT_BLU_MAG: begin
                r4_next = xx3_reg; g4_next = '0; b4_next = cc3_reg;
            end
            default: begin
                r4_next = cc3_reg; g4_next = '0; b4_next = xx3_reg;
            end
        endcase
        wsum = NW'(r4_next) * NW'(WEIGHT_R) + NW'(g4_next) * NW'(WEIGHT_G)
             + NW'(b4_next) * NW'(WEIGHT_B);
        base4_next = NW'(lw3_reg) * NW'(WEIGHT_SUM) - wsum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hue1_reg  <= hue1_next;
            c1_reg    <= c1_next;
            l1_reg    <= l1_next;
            qd1_reg   <= qd1_next;
            sect2_reg <= sect2_next;
            pos2_reg  <= pos2_next;
            c2_reg    <= c2_next;
            l2_reg    <= l2_next;
            sect3_reg <= sect3_next;
            cc3_reg   <= cc3_next;
            xx3_reg   <= xx3_next;
            lw3_reg   <= lw3_next;
            r4_reg    <= r4_next;
            g4_reg    <= g4_next;
            b4_reg    <= b4_next;
            base4_reg <= base4_next;
        end
    end

    hcl2rgb_chan #(.PW(PW), .NW(NW), .K(K)) u_chan_r (
        .aclk    (aclk),
        .advance (advance),
        .ch      (r4_reg),
        .base    (base4_reg),
        .res     (res_r)
    );

    hcl2rgb_chan #(.PW(PW), .NW(NW), .K(K)) u_chan_g (
        .aclk    (aclk),
        .advance (advance),
        .ch      (g4_reg),
        .base    (base4_reg),
        .res     (res_g)
    );

    hcl2rgb_chan #(.PW(PW), .NW(NW), .K(K)) u_chan_b (
        .aclk    (aclk),
        .advance (advance),
        .ch      (b4_reg),
        .base    (base4_reg),
        .res     (res_b)
    );

    assign m_tvalid = valid_reg[DEPTH-1];
    assign m_tdata  = {res_b.value, res_g.value, res_r.value};
    assign m_tuser  = res_r.clip | res_g.clip | res_b.clip;

endmodule

`default_nettype wire

// ----- test/hcl_to_rgb_convert_tb.sv -----
// ----------------------------------------------------------------------------
// hcl_to_rgb_convert_tb: self-checking bench for the HCL to RGB converter
// Streams hue/chroma/luma requests through the converter, predicts every RGB
// triple and clip flag in exact integer arithmetic, and checks the results
// in order under random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module hcl_to_rgb_convert_tb;
    import hcl2rgb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SECTOR_SPAN = 60 << 6;           // one sector in hue units
    localparam longint HUE_TURN    = SECTOR_SPAN * 6;   // 360 degrees
    localparam longint CHAN_DEN    = longint'(WEIGHT_SUM) * SECTOR_SPAN * 65536;
    localparam int     RANDOM_REQS = 1450;
    localparam int     HOLD_AT     = 1100;
    localparam int     HOLD_CYCLES = 300;
    localparam int     QUIET_CYCLES = 20;
    localparam int     CYCLE_LIMIT = 200000;

    typedef struct {
        logic [55:0] data;
        int          phase;
    } hcl_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       clip;
    } rgb_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // hue_angle[14:0], chroma_level[31:15], luma_level[48:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic        m_tuser;   // clipped

    hcl_req_t hcl_pending[$];
    rgb_t     rgb_expected[$];
    hcl_req_t drive_req;
    int       send_idle_pct[3] = '{24, 83, 0};
    int       recv_idle_pct[3] = '{83, 24, 0};
    int       active_phase = 0;
    int       sent_count = 0;
    int       error_count = 0;
    int       cycle_count = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    bit       running = 1'b0;
    bit       req_taken = 1'b0;

    hcl_to_rgb_convert #(
        .LEVEL_QBITS(16),
        .HUE_QBITS  (6)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    function automatic logic [55:0] pack_hcl(int hue, int chroma, int luma);
        logic [14:0] h;
        logic [16:0] c;
        logic [16:0] l;
        h = hue[14:0];
        c = chroma[16:0];
        l = luma[16:0];
        return {7'd0, l, c, h};
    endfunction

    // Scale by 255 over the common denominator, round half away from zero
    function automatic chan_res_t scale_channel(longint num);
        longint    n;
        longint    v;
        chan_res_t res;
        n = num * 255;
        if (n >= 0) begin
            v = (2 * n + CHAN_DEN) / (2 * CHAN_DEN);
        end else begin
            v = -((-2 * n + CHAN_DEN) / (2 * CHAN_DEN));
        end
        res.clip = 1'b0;
        if (v < 0) begin
            res.value = 8'd0;
            res.clip  = 1'b1;
        end else if (v > 255) begin
            res.value = 8'd255;
            res.clip  = 1'b1;
        end else begin
            res.value = v[7:0];
        end
        return res;
    endfunction

    function automatic rgb_t hcl_to_rgb(logic [55:0] d);
        longint    hue;
        longint    chroma;
        longint    luma;
        longint    sect;
        longint    pos;
        longint    ramp;
        longint    cc;
        longint    xx;
        longint    r;
        longint    g;
        longint    b;
        longint    m;
        chan_res_t cr;
        chan_res_t cg;
        chan_res_t cb;
        rgb_t      res;
        hue    = longint'(d[14:0]) % HUE_TURN;
        chroma = longint'(d[31:15]);
        luma   = longint'(d[48:32]);
        sect   = hue / SECTOR_SPAN;
        pos    = hue % SECTOR_SPAN;
        ramp   = sect[0] ? (SECTOR_SPAN - pos) : pos;
        cc     = chroma * SECTOR_SPAN;
        xx     = chroma * ramp;
        case (sector_t'(sect[2:0]))
            SECT_RED_YEL: begin r = cc; g = xx; b = 0; end
            SECT_YEL_GRN: begin r = xx; g = cc; b = 0; end
            SECT_GRN_CYN: begin r = 0;  g = cc; b = xx; end
            SECT_CYN_BLU: begin r = 0;  g = xx; b = cc; end
            SECT_BLU_MAG: begin r = xx; g = 0;  b = cc; end
            default:      begin r = cc; g = 0;  b = xx; end
        endcase
        // lift the weighted sum up to the requested luma
        m  = luma * SECTOR_SPAN * WEIGHT_SUM - (WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b);
        cr = scale_channel(WEIGHT_SUM * r + m);
        cg = scale_channel(WEIGHT_SUM * g + m);
        cb = scale_channel(WEIGHT_SUM * b + m);
        res.red   = cr.value;
        res.green = cg.value;
        res.blue  = cb.value;
        res.clip  = cr.clip | cg.clip | cb.clip;
        return res;
    endfunction

    function automatic int pick_level();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8) begin
            return 0;
        end else if (sel < 16) begin
            return 65536;
        end else if (sel < 30) begin
            return $urandom_range(131071);
        end
        return $urandom_range(65536);
    endfunction

    task automatic add_request(logic [55:0] data, int phase);
        hcl_req_t req;
        req.data  = data;
        req.phase = phase;
        hcl_pending.push_back(req);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sender: hold a request until taken, otherwise offer the next or idle
    always @(negedge aclk) begin
        if (running && (!s_tvalid || req_taken)) begin
            if (hcl_pending.size() != 0 &&
                $urandom_range(99) >= send_idle_pct[hcl_pending[0].phase]) begin
                drive_req    = hcl_pending.pop_front();
                active_phase = drive_req.phase;
                s_tdata  <= drive_req.data;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Receiver: random backpressure plus one long hold-off
    always @(negedge aclk) begin
        if (running) begin
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct[active_phase]);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rgb_expected.push_back(hcl_to_rgb(s_tdata));
                sent_count++;
                req_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch("result without request", 1, 0);
                end else begin
                    rgb_t want;
                    want = rgb_expected.pop_front();
                    if (m_tdata[7:0] !== want.red)
                        report_mismatch("red_out", int'(m_tdata[7:0]), int'(want.red));
                    if (m_tdata[15:8] !== want.green)
                        report_mismatch("green_out", int'(m_tdata[15:8]), int'(want.green));
                    if (m_tdata[23:16] !== want.blue)
                        report_mismatch("blue_out", int'(m_tdata[23:16]), int'(want.blue));
                    if (m_tuser !== want.clip)
                        report_mismatch("clipped", int'(m_tuser), int'(want.clip));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int hue;
        int phase;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;

        // corners and sector boundaries
        add_request(pack_hcl(0, 0, 0), 0);
        add_request(pack_hcl(0, 65536, 65536), 0);
        add_request(pack_hcl(23039, 65536, 0), 0);
        add_request(pack_hcl(3839, 65536, 32768), 0);
        add_request(pack_hcl(3840, 65536, 32768), 0);
        add_request(pack_hcl(7680, 65536, 32768), 0);
        add_request(pack_hcl(11520, 65536, 32768), 0);
        add_request(pack_hcl(15360, 65536, 32768), 0);
        add_request(pack_hcl(19200, 65536, 32768), 0);
        for (int k = 0; k < 6; k++) begin
            add_request(pack_hcl(1920 + 3840 * k, 40000, 30000), 0);
        end
        // hue past a full turn wraps around
        add_request(pack_hcl(23040, 50000, 20000), 0);
        add_request(pack_hcl(32767, 131071, 131071), 0);
        // chroma and luma above 1.0
        add_request(pack_hcl(5000, 131071, 0), 0);
        add_request(pack_hcl(12000, 0, 131071), 0);
        // a slightly negative channel that rounds to zero without clipping, and one that clips at zero
        add_request(pack_hcl(0, 100, 0), 0);
        add_request(pack_hcl(9000, 65536, 0), 0);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            phase = (i * 3) / RANDOM_REQS;
            if ($urandom_range(9) == 0) begin
                hue = $urandom_range(32767, 23040);
            end else if ($urandom_range(9) == 0) begin
                hue = 3840 * $urandom_range(5) + $urandom_range(1) * 3839;
            end else begin
                hue = $urandom_range(23039);
            end
            add_request(pack_hcl(hue, pick_level(), pick_level()), phase);
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        running = 1'b1;

        while (hcl_pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (rgb_expected.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
